@@ rtl/core/opp_pkg.sv @@
// ----------------------------------------------------------------------------
// opp_pkg
// Shared types and constants of the offline pong packet parser.
// ----------------------------------------------------------------------------
package opp_pkg;

	localparam int MAX_PACKET_BYTES = 4096;
	localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
	localparam int TDATA_W          = 176;
	localparam int MAX_RES          = 3;

	localparam logic [7:0] PONG_ID    = 8'h1c;
	localparam logic [7:0] SEMICOLON  = 8'h3b;
	localparam int         MIN_PONG   = 35;
	localparam int         TEXT_START = 35;

	localparam logic [7:0] MAGIC [16] = '{
		8'h00, 8'hff, 8'hff, 8'h00, 8'hfe, 8'hfe, 8'hfe, 8'hfe,
		8'hfd, 8'hfd, 8'hfd, 8'hfd, 8'h12, 8'h34, 8'h56, 8'h78
	};

	typedef enum logic [1:0] {
		KIND_TEXT = 2'd0,
		KIND_NUM  = 2'd1,
		KIND_SUM  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_BAD_ID  = 3'd2,
		ST_BAD_MAG = 3'd3,
		ST_OVERRUN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		NP_SKIP  = 2'd0,
		NP_SIGN  = 2'd1,
		NP_DIGIT = 2'd2,
		NP_STOP  = 2'd3
	} num_phase_t;

	typedef struct packed {
		kind_t              kind;
		logic [3:0]         part;
		logic [7:0]         motd;
		logic signed [31:0] num;
		status_t            status;
		logic [63:0]        ping;
		logic [63:0]        guid;
		logic               last;
	} res_t;

	// results produced by one accepted item
	typedef struct packed {
		logic       push;
		logic [1:0] count;
	} push_t;

endpackage

@@ rtl/core/opp_parse.sv @@
// ----------------------------------------------------------------------------
// opp_parse
// Per-packet parse state and result generation for one datagram byte.
// ----------------------------------------------------------------------------
module opp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                end_of_packet,
	output opp_pkg::push_t      push,
	output opp_pkg::res_t       res [opp_pkg::MAX_RES]
);

	logic [opp_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]                code_q, code_d;
	logic [63:0]               ping_q, ping_d;
	logic [63:0]               guid_q, guid_d;
	logic                      magic_q, magic_d;
	logic [15:0]               tlen_q, tlen_d;
	logic [15:0]               seen_q, seen_d;
	logic [3:0]                part_q, part_d;
	opp_pkg::num_phase_t       phase_q, phase_d;
	logic                      neg_q, neg_d;
	logic [31:0]               mag_q, mag_d;
	logic                      ovf_q, ovf_d;

	logic [35:0]               mag_next;
	logic [31:0]               digit;
	logic                      is_digit;
	logic                      is_space;
	logic [1:0]                n;
	opp_pkg::status_t          st;

	function automatic logic is_num_part(input logic [3:0] p);
		return p inside {4'd2, 4'd4, 4'd5, 4'd9, 4'd10, 4'd11};
	endfunction

	function automatic logic [31:0] num_value(input opp_pkg::num_phase_t ph, input logic ng,
		input logic [31:0] mg, input logic ov);
		logic [31:0] v;
		if (ph == opp_pkg::NP_SKIP || ph == opp_pkg::NP_SIGN || ov)
			v = 32'hffff_ffff;
		else if (ng)
			v = 32'd0 - mg;
		else if (mg[31])
			v = 32'hffff_ffff;
		else
			v = mg;
		return v;
	endfunction

	function automatic opp_pkg::res_t mk_res(input opp_pkg::kind_t k, input logic [3:0] p,
		input logic [7:0] b, input logic [31:0] v);
		opp_pkg::res_t r;
		r        = '0;
		r.kind   = k;
		r.part   = p;
		r.motd   = b;
		r.num    = v;
		r.status = opp_pkg::ST_OK;
		return r;
	endfunction

	assign is_digit = data_byte inside {[8'h30:8'h39]};
	assign is_space = data_byte inside {8'h20, [8'h09:8'h0d]};
	assign digit    = {28'd0, data_byte[3:0]};
	assign mag_next = {4'd0, mag_q} * 36'd10 + {4'd0, digit};

	always_comb begin
		cnt_d   = cnt_q;
		code_d  = code_q;
		ping_d  = ping_q;
		guid_d  = guid_q;
		magic_d = magic_q;
		tlen_d  = tlen_q;
		seen_d  = seen_q;
		part_d  = part_q;
		phase_d = phase_q;
		neg_d   = neg_q;
		mag_d   = mag_q;
		ovf_d   = ovf_q;
		n       = 2'd0;
		st      = opp_pkg::ST_OK;
		for (int i = 0; i < opp_pkg::MAX_RES; i++)
			res[i] = '0;

		if (cnt_q < opp_pkg::CNT_W'(opp_pkg::MAX_PACKET_BYTES)) begin
			if (cnt_q == '0) begin
				code_d = data_byte;
			end else if (cnt_q <= opp_pkg::CNT_W'(8)) begin
				ping_d = {ping_q[55:0], data_byte};
			end else if (cnt_q <= opp_pkg::CNT_W'(16)) begin
				guid_d = {guid_q[55:0], data_byte};
			end else if (cnt_q <= opp_pkg::CNT_W'(32)) begin
				if (data_byte != opp_pkg::MAGIC[cnt_q[3:0] - 4'd1])
					magic_d = 1'b0;
			end else if (cnt_q <= opp_pkg::CNT_W'(34)) begin
				tlen_d = {tlen_q[7:0], data_byte};
			end else if (seen_q < tlen_q && code_q == opp_pkg::PONG_ID && magic_q) begin
				res[0] = mk_res(opp_pkg::KIND_TEXT, part_q, data_byte, 32'd0);
				n      = 2'd1;
				seen_d = seen_q + 16'd1;
				if (data_byte == opp_pkg::SEMICOLON) begin
					if (is_num_part(part_q)) begin
						res[1] = mk_res(opp_pkg::KIND_NUM, part_q, 8'd0,
							num_value(phase_q, neg_q, mag_q, ovf_q));
						n      = 2'd2;
					end
					if (part_q < 4'd12)
						part_d = part_q + 4'd1;
					phase_d = opp_pkg::NP_SKIP;
					neg_d   = 1'b0;
					mag_d   = 32'd0;
					ovf_d   = 1'b0;
				end else begin
					case (phase_q)
						opp_pkg::NP_SKIP: begin
							if (!is_space) begin
								if (data_byte == 8'h2b || data_byte == 8'h2d) begin
									neg_d   = (data_byte == 8'h2d);
									phase_d = opp_pkg::NP_SIGN;
								end else if (is_digit) begin
									mag_d   = digit;
									phase_d = opp_pkg::NP_DIGIT;
								end else begin
									ovf_d   = 1'b1;
									phase_d = opp_pkg::NP_STOP;
								end
							end
						end
						opp_pkg::NP_SIGN: begin
							if (is_digit) begin
								mag_d   = digit;
								phase_d = opp_pkg::NP_DIGIT;
							end else begin
								ovf_d   = 1'b1;
								phase_d = opp_pkg::NP_STOP;
							end
						end
						opp_pkg::NP_DIGIT: begin
							if (is_digit) begin
								if (!ovf_q) begin
									if (mag_next > 36'h0_8000_0000)
										ovf_d = 1'b1;
									else
										mag_d = mag_next[31:0];
								end
							end else begin
								phase_d = opp_pkg::NP_STOP;
							end
						end
						default: ;
					endcase
					if (seen_d == tlen_q && is_num_part(part_q)) begin
						res[1] = mk_res(opp_pkg::KIND_NUM, part_q, 8'd0,
							num_value(phase_d, neg_d, mag_d, ovf_d));
						n      = 2'd2;
					end
				end
			end
			cnt_d = cnt_q + opp_pkg::CNT_W'(1);
		end

		if (end_of_packet) begin
			if (cnt_d < opp_pkg::CNT_W'(opp_pkg::MIN_PONG))
				st = opp_pkg::ST_SHORT;
			else if (code_d != opp_pkg::PONG_ID)
				st = opp_pkg::ST_BAD_ID;
			else if (!magic_d)
				st = opp_pkg::ST_BAD_MAG;
			else if (18'(tlen_d) + 18'(opp_pkg::TEXT_START) > 18'(cnt_d))
				st = opp_pkg::ST_OVERRUN;
			else
				st = opp_pkg::ST_OK;
			res[n]        = '0;
			res[n].kind   = opp_pkg::KIND_SUM;
			res[n].status = st;
			res[n].ping   = ping_d;
			res[n].guid   = guid_d;
			res[n].last   = 1'b1;
			n             = n + 2'd1;
			cnt_d   = '0;
			code_d  = 8'd0;
			ping_d  = 64'd0;
			guid_d  = 64'd0;
			magic_d = 1'b1;
			tlen_d  = 16'd0;
			seen_d  = 16'd0;
			part_d  = 4'd0;
			phase_d = opp_pkg::NP_SKIP;
			neg_d   = 1'b0;
			mag_d   = 32'd0;
			ovf_d   = 1'b0;
		end
	end

	assign push.push  = accept;
	assign push.count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			code_q  <= 8'd0;
			ping_q  <= 64'd0;
			guid_q  <= 64'd0;
			magic_q <= 1'b1;
			tlen_q  <= 16'd0;
			seen_q  <= 16'd0;
			part_q  <= 4'd0;
			phase_q <= opp_pkg::NP_SKIP;
			neg_q   <= 1'b0;
			mag_q   <= 32'd0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			cnt_q   <= cnt_d;
			code_q  <= code_d;
			ping_q  <= ping_d;
			guid_q  <= guid_d;
			magic_q <= magic_d;
			tlen_q  <= tlen_d;
			seen_q  <= seen_d;
			part_q  <= part_d;
			phase_q <= phase_d;
			neg_q   <= neg_d;
			mag_q   <= mag_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

@@ rtl/core/opp_outq.sv @@
// ----------------------------------------------------------------------------
// opp_outq
// Four-slot result queue; takes up to three results per item, emits one.
// ----------------------------------------------------------------------------
module opp_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  opp_pkg::push_t push,
	input  opp_pkg::res_t  res [opp_pkg::MAX_RES],
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output opp_pkg::res_t  out_res
);

	opp_pkg::res_t slot_q [4];
	opp_pkg::res_t slot_d [4];
	logic [2:0]    cnt_q, cnt_d;
	logic [2:0]    cnt_mid;
	logic          pop;

	assign pop       = (cnt_q != 3'd0) && out_ready;
	assign in_ready  = (cnt_q <= 3'd1);
	assign out_valid = (cnt_q != 3'd0);
	assign out_res   = slot_q[0];

	always_comb begin
		slot_d  = slot_q;
		cnt_mid = cnt_q - {2'd0, pop};
		if (pop) begin
			slot_d[0] = slot_q[1];
			slot_d[1] = slot_q[2];
			slot_d[2] = slot_q[3];
		end
		cnt_d = cnt_mid;
		if (push.push) begin
			for (int i = 0; i < opp_pkg::MAX_RES; i++) begin
				if (2'(i) < push.count)
					slot_d[cnt_mid[1:0] + 2'(i)] = res[i];
			end
			cnt_d = cnt_mid + {1'b0, push.count};
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

endmodule

@@ rtl/core/offline_pong_packet_parser.sv @@
// ----------------------------------------------------------------------------
// offline_pong_packet_parser
// Parses an offline pong datagram byte stream into string bytes, part numbers
// and a per-packet summary.
//
// Input channel s_*: one datagram byte per item, s_tlast on the final byte.
// Output channel m_*: result items; m_tuser is the result kind, m_tlast marks
// the packet summary. String bytes and numbers are valid only if the summary
// status that follows is ok.
// The results of an accepted byte are registered in the result queue first.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_tready stays high; a byte giving two or three results holds s_tready low
// until the four-slot result queue drains to at most one result.
// Reset: arst_n clears the parse state and empties the queue.
// Stall: with m_tready low the queue holds its results and s_tready drops once
// more than one result is waiting.
// ----------------------------------------------------------------------------
module offline_pong_packet_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] data_byte
	input  logic                        s_tlast,   // end_of_packet
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [opp_pkg::TDATA_W-1:0] m_tdata,   // part_index, motd_byte, number_value,
	                                               // status, ping_time, server_guid,
	                                               // zero pad
	output logic [1:0]                  m_tuser,   // [1:0] result_kind
	output logic                        m_tlast    // last_of_run
);

	opp_pkg::push_t push;
	opp_pkg::res_t  res [opp_pkg::MAX_RES];
	opp_pkg::res_t  out_res;
	logic           accept;

	assign accept = s_tvalid && s_tready;

	opp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (s_tdata),
		.end_of_packet (s_tlast),
		.push          (push),
		.res           (res)
	);

	opp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {1'b0, out_res.guid, out_res.ping, out_res.status, out_res.num,
		out_res.motd, out_res.part};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

endmodule

@@ dv/offline_pong_packet_parser_test.sv @@
// ----------------------------------------------------------------------------
// offline_pong_packet_parser_test
// Self-checking bench for the offline pong packet parser. A short table of
// header-only datagrams with known summaries comes first. Fixed and random
// pong datagrams follow: well-formed, bad id, bad magic, overrun, short and
// noise datagrams. They are checked against a cycle-free parse model.
// Bursty input, random and patterned output stalls and one long output hold-off
// exercise the result queue.
// ----------------------------------------------------------------------------
module offline_pong_packet_parser_test;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int ITEMS_TOTAL = 450;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTS  = 40;
	localparam logic [3:0] PART_SAT = 4'd12;

	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] WS [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

	typedef struct {
		logic [7:0]       b;
		logic             eop;
		bit               typed;
		opp_pkg::status_t st;
		logic [63:0]      ping;
		logic [63:0]      guid;
	} dir_row_t;

	typedef struct {
		logic [7:0]    b;
		logic          eop;
		bit            typed;
		opp_pkg::res_t res;
	} feed_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [7:0]                  s_tdata = 8'h00;  // [7:0] data_byte
	logic                        s_tlast = 1'b0;   // end_of_packet
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [opp_pkg::TDATA_W-1:0] m_tdata;          // part_index, motd_byte, number_value,
	                                               // status, ping_time, server_guid,
	                                               // zero pad
	logic [1:0]                  m_tuser;          // [1:0] result_kind
	logic                        m_tlast;          // last_of_run

	offline_pong_packet_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// header-only datagrams, summary known by inspection
	dir_row_t dir_tab [24] = '{
		'{8'h00, 1'b1, 1'b1, opp_pkg::ST_SHORT, 64'h0, 64'h0},
		'{8'hff, 1'b1, 1'b1, opp_pkg::ST_SHORT, 64'h0, 64'h0},
		'{8'h1c, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hff, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hff, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hff, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hff, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hff, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hff, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hff, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hff, 1'b1, 1'b1, opp_pkg::ST_SHORT, 64'hffff_ffff_ffff_ffff, 64'h0},
		'{8'h1c, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'h80, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'h01, 1'b1, 1'b1, opp_pkg::ST_SHORT, 64'h8001, 64'h0},
		'{8'h00, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'h12, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'h34, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'h56, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'h78, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'h9a, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hbc, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hde, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'hf0, 1'b0, 1'b0, opp_pkg::ST_OK, 64'h0, 64'h0},
		'{8'haa, 1'b1, 1'b1, opp_pkg::ST_SHORT, 64'h1234_5678_9abc_def0, 64'haa}
	};

	feed_t         feed_q [$];
	opp_pkg::res_t expected_q [$];
	opp_pkg::res_t step_q [$];
	logic [7:0]    text_buf [$];

	int errors = 0;
	int items_sent = 0;
	int packets_sent = 0;
	int results_seen = 0;
	int cycle_cnt = 0;

	// parse model state
	int unsigned         pos_cnt;
	logic [7:0]          id_byte;
	logic [63:0]         ping_acc;
	logic [63:0]         guid_acc;
	bit                  magic_ok;
	logic [15:0]         str_len;
	logic [15:0]         str_cnt;
	logic [3:0]          part_no;
	opp_pkg::num_phase_t np;
	bit                  neg;
	logic [31:0]         mag;
	bit                  ovf;

	function automatic opp_pkg::res_t make_res(opp_pkg::kind_t k, logic [3:0] p,
			logic [7:0] m, logic [31:0] n, opp_pkg::status_t s, logic [63:0] pt,
			logic [63:0] gd, logic l);
		opp_pkg::res_t r;
		r.kind   = k;
		r.part   = p;
		r.motd   = m;
		r.num    = n;
		r.status = s;
		r.ping   = pt;
		r.guid   = gd;
		r.last   = l;
		return r;
	endfunction

	task automatic clear_number();
		np  = opp_pkg::NP_SKIP;
		neg = 1'b0;
		mag = '0;
		ovf = 1'b0;
	endtask

	task automatic clear_packet();
		pos_cnt  = 0;
		id_byte  = '0;
		ping_acc = '0;
		guid_acc = '0;
		magic_ok = 1'b1;
		str_len  = '0;
		str_cnt  = '0;
		part_no  = '0;
		clear_number();
	endtask

	function automatic bit is_numeric(logic [3:0] p);
		return p inside {4'd2, 4'd4, 4'd5, 4'd9, 4'd10, 4'd11};
	endfunction

	function automatic logic [31:0] part_number();
		if (np == opp_pkg::NP_SKIP || np == opp_pkg::NP_SIGN || ovf)
			return '1;
		if (neg)
			return 32'(0 - mag);
		if (mag > 32'h7fff_ffff)
			return '1;
		return mag;
	endfunction

	task automatic feed_number(input logic [7:0] c);
		bit dig;
		bit sp;
		logic [31:0] d;
		logic [63:0] nxt;
		dig = (c >= CH_ZERO && c <= CH_NINE);
		d   = {28'b0, 4'(c - CH_ZERO)};
		sp  = (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
		case (np)
			opp_pkg::NP_SKIP: begin
				if (!sp) begin
					if (c == CH_PLUS || c == CH_MINUS) begin
						neg = (c == CH_MINUS);
						np  = opp_pkg::NP_SIGN;
					end else if (dig) begin
						mag = d;
						np  = opp_pkg::NP_DIGIT;
					end else begin
						ovf = 1'b1;
						np  = opp_pkg::NP_STOP;
					end
				end
			end
			opp_pkg::NP_SIGN: begin
				if (dig) begin
					mag = d;
					np  = opp_pkg::NP_DIGIT;
				end else begin
					ovf = 1'b1;
					np  = opp_pkg::NP_STOP;
				end
			end
			opp_pkg::NP_DIGIT: begin
				if (dig) begin
					if (!ovf) begin
						nxt = {32'b0, mag} * 64'd10 + {32'b0, d};
						if (nxt > 64'd2147483648)
							ovf = 1'b1;
						else
							mag = nxt[31:0];
					end
				end else begin
					np = opp_pkg::NP_STOP;
				end
			end
			default: ;
		endcase
	endtask

	// results of one accepted byte go to step_q
	task automatic parse_byte(input logic [7:0] b, input logic eop);
		logic [3:0] part;
		opp_pkg::status_t st;
		if (pos_cnt < opp_pkg::MAX_PACKET_BYTES) begin
			if (pos_cnt == 0) begin
				id_byte = b;
			end else if (pos_cnt <= 8) begin
				ping_acc = {ping_acc[55:0], b};
			end else if (pos_cnt <= 16) begin
				guid_acc = {guid_acc[55:0], b};
			end else if (pos_cnt <= 32) begin
				if (b != opp_pkg::MAGIC[pos_cnt - 17])
					magic_ok = 1'b0;
			end else if (pos_cnt <= 34) begin
				str_len = {str_len[7:0], b};
			end else if (str_cnt < str_len && id_byte == opp_pkg::PONG_ID && magic_ok) begin
				part = part_no;
				step_q = {step_q, make_res(opp_pkg::KIND_TEXT, part, b, '0, opp_pkg::ST_OK,
					'0, '0, 1'b0)};
				str_cnt = str_cnt + 16'd1;
				if (b == opp_pkg::SEMICOLON) begin
					if (is_numeric(part))
						step_q = {step_q, make_res(opp_pkg::KIND_NUM, part, '0,
							part_number(), opp_pkg::ST_OK, '0, '0, 1'b0)};
					if (part_no < PART_SAT)
						part_no = part_no + 4'd1;
					clear_number();
				end else begin
					feed_number(b);
					if (str_cnt == str_len && is_numeric(part))
						step_q = {step_q, make_res(opp_pkg::KIND_NUM, part, '0,
							part_number(), opp_pkg::ST_OK, '0, '0, 1'b0)};
				end
			end
			pos_cnt++;
		end
		if (eop) begin
			if (pos_cnt < opp_pkg::MIN_PONG)
				st = opp_pkg::ST_SHORT;
			else if (id_byte != opp_pkg::PONG_ID)
				st = opp_pkg::ST_BAD_ID;
			else if (!magic_ok)
				st = opp_pkg::ST_BAD_MAG;
			else if (opp_pkg::TEXT_START + int'(str_len) > int'(pos_cnt))
				st = opp_pkg::ST_OVERRUN;
			else
				st = opp_pkg::ST_OK;
			step_q = {step_q, make_res(opp_pkg::KIND_SUM, '0, '0, '0, st, ping_acc,
				guid_acc, 1'b1)};
			clear_packet();
		end
	endtask

	task automatic add_item(input logic [7:0] b, input logic eop);
		feed_t f;
		f.b     = b;
		f.eop   = eop;
		f.typed = 1'b0;
		f.res   = '0;
		feed_q  = {feed_q, f};
	endtask

	task automatic load_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf = {text_buf, 8'(s[i])};
	endtask

	// status string of random parts, numeric-looking ones weighted in
	task automatic make_text();
		int parts;
		int c;
		int n;
		string bound_str;
		text_buf.delete();
		parts = $urandom_range(1, 15);
		for (int p = 0; p < parts; p++) begin
			if (p > 0)
				text_buf = {text_buf, opp_pkg::SEMICOLON};
			c = $urandom_range(0, 9);
			if (c < 6) begin
				n = $urandom_range(0, 2);
				repeat (n) text_buf = {text_buf, WS[$urandom_range(0, 5)]};
				case ($urandom_range(0, 3))
					0: text_buf = {text_buf, CH_PLUS};
					1: text_buf = {text_buf, CH_MINUS};
					default: ;
				endcase
				if (c == 0) begin
					case ($urandom_range(0, 4))
						0: bound_str = "2147483647";
						1: bound_str = "2147483648";
						2: bound_str = "4294967295";
						3: bound_str = "4294967296";
						default: bound_str = "0";
					endcase
					for (int i = 0; i < bound_str.len(); i++)
						text_buf = {text_buf, 8'(bound_str[i])};
				end else begin
					n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
					repeat (n) text_buf = {text_buf, 8'(CH_ZERO + 8'($urandom_range(0, 9)))};
				end
				if ($urandom_range(0, 3) == 0)
					text_buf = {text_buf, 8'($urandom_range(8'h40, 8'h7e))};
			end else begin
				n = $urandom_range(0, 6);
				repeat (n) text_buf = {text_buf, 8'($urandom_range(0, 255))};
			end
		end
		if ($urandom_range(0, 3) == 0)
			text_buf = {text_buf, opp_pkg::SEMICOLON};
	endtask

	// header + text_buf; total > 0 trims or pads the datagram to that size
	task automatic queue_pong(input logic [7:0] id, input bit spoil, input logic [15:0] len,
			input int total);
		logic [7:0] pk [$];
		int k;
		pk = {pk, id};
		repeat (16) pk = {pk, 8'($urandom_range(0, 255))};
		k = spoil ? $urandom_range(0, 15) : -1;
		for (int i = 0; i < 16; i++)
			pk = {pk, (i == k) ? (opp_pkg::MAGIC[i] ^ 8'($urandom_range(1, 255))) :
				opp_pkg::MAGIC[i]};
		pk = {pk, len[15:8]};
		pk = {pk, len[7:0]};
		foreach (text_buf[i])
			pk = {pk, text_buf[i]};
		if (total > 0) begin
			while (pk.size() > total)
				void'(pk.pop_back());
			while (pk.size() < total)
				pk = {pk, 8'($urandom_range(0, 255))};
		end
		foreach (pk[i])
			add_item(pk[i], i == pk.size() - 1);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got_v,
			input logic [63:0] want_v);
		if (errors < MAX_PRINTS)
			$display("mismatch at result %0d: %s got %h want %h", results_seen, what, got_v,
				want_v);
		errors++;
	endtask

	// sender: bursts with random gaps, predicts on every accepted item
	int            burst_left = 0;
	int            gap_left = 0;
	bit            cur_typed = 1'b0;
	opp_pkg::res_t cur_res;
	feed_t         next_item;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tlast);
				if (cur_typed)
					expected_q = {expected_q, cur_res};
				else
					foreach (step_q[i])
						expected_q = {expected_q, step_q[i]};
				step_q.delete();
				items_sent++;
				if (s_tlast)
					packets_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || feed_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					next_item = feed_q.pop_front();
					s_tdata   <= next_item.b;
					s_tlast   <= next_item.eop;
					s_tvalid  <= 1'b1;
					cur_typed = next_item.typed;
					cur_res   = next_item.res;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
					end
				end
			end
		end
	end

	// receiver: stall modes of random length, plus one long hold-off
	int         hold_left = 0;
	bit         hold_done = 1'b0;
	int         rx_mode = 0;
	int         mode_left = 0;
	logic [15:0] rx_pattern = 16'h0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && results_seen >= 40) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				rx_mode    = $urandom_range(0, 3);
				mode_left  = $urandom_range(16, 96);
				rx_pattern = 16'($urandom);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: begin
						m_tready   <= rx_pattern[0];
						rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_blk
		opp_pkg::res_t got;
		opp_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind   = opp_pkg::kind_t'(m_tuser);
			got.part   = m_tdata[3:0];
			got.motd   = m_tdata[11:4];
			got.num    = m_tdata[43:12];
			got.status = opp_pkg::status_t'(m_tdata[46:44]);
			got.ping   = m_tdata[110:47];
			got.guid   = m_tdata[174:111];
			got.last   = m_tlast;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result, kind", 64'(got.kind), '0);
			end else begin
				want = expected_q.pop_front();
				if (got.kind !== want.kind)
					report_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
				if (got.part !== want.part)
					report_mismatch("part_index", 64'(got.part), 64'(want.part));
				if (got.motd !== want.motd)
					report_mismatch("motd_byte", 64'(got.motd), 64'(want.motd));
				if (got.num !== want.num)
					report_mismatch("number_value", 64'(got.num), 64'(want.num));
				if (got.status !== want.status)
					report_mismatch("status", 64'(got.status), 64'(want.status));
				if (got.ping !== want.ping)
					report_mismatch("ping_time", got.ping, want.ping);
				if (got.guid !== want.guid)
					report_mismatch("server_guid", got.guid, want.guid);
				if (got.last !== want.last)
					report_mismatch("last_of_run", 64'(got.last), 64'(want.last));
			end
			results_seen <= results_seen + 1;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycle_cnt,
				expected_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : main_blk
		feed_t f;
		int c;
		int len;
		logic [7:0] id;

		clear_packet();

		foreach (dir_tab[i]) begin
			f.b     = dir_tab[i].b;
			f.eop   = dir_tab[i].eop;
			f.typed = dir_tab[i].typed;
			f.res   = make_res(opp_pkg::KIND_SUM, '0, '0, '0, dir_tab[i].st, dir_tab[i].ping,
				dir_tab[i].guid, 1'b1);
			feed_q  = {feed_q, f};
		end

		// whitespace, signs, 32-bit limits, empty parts, part index saturation
		load_text({"MCPE;motd; \011\012\013\014\015-42;1;+2147483647;-2147483648x;a;b;c;",
			"2147483648;;-;x;y;z"});
		queue_pong(opp_pkg::PONG_ID, 1'b0, 16'(text_buf.size()), 0);
		// number closed by string end, then trailing bytes
		load_text("a;b;;c;99999999999;x;1;2;3;4294967296; 00012");
		queue_pong(opp_pkg::PONG_ID, 1'b0, 16'(text_buf.size()),
			opp_pkg::TEXT_START + text_buf.size() + 3);

		while (feed_q.size() < ITEMS_TOTAL) begin
			make_text();
			c = $urandom_range(0, 99);
			if (c < 62) begin
				queue_pong(opp_pkg::PONG_ID, 1'b0, 16'(text_buf.size()),
					($urandom_range(0, 2) == 0) ?
					opp_pkg::TEXT_START + text_buf.size() + $urandom_range(1, 4) : 0);
			end else if (c < 70) begin
				id = 8'($urandom_range(0, 255));
				if (id == opp_pkg::PONG_ID)
					id = id ^ 8'h01;
				queue_pong(id, 1'b0, 16'(text_buf.size()), 0);
			end else if (c < 78) begin
				queue_pong(opp_pkg::PONG_ID, 1'b1, 16'(text_buf.size()), 0);
			end else if (c < 86) begin
				if ($urandom_range(0, 1) == 0)
					queue_pong(opp_pkg::PONG_ID, 1'b0, 16'(text_buf.size()),
						opp_pkg::TEXT_START + $urandom_range(0, text_buf.size()));
				else
					queue_pong(opp_pkg::PONG_ID, 1'b0, ($urandom_range(0, 4) == 0) ? 16'hffff :
						16'(text_buf.size() + $urandom_range(1, 30)), 0);
			end else if (c < 94) begin
				queue_pong(opp_pkg::PONG_ID, 1'b0, 16'(text_buf.size()),
					$urandom_range(1, opp_pkg::MIN_PONG - 1));
			end else begin
				len = $urandom_range(1, 50);
				for (int i = 0; i < len; i++)
					add_item(8'($urandom_range(0, 255)), i == len - 1);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (feed_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("%0d bytes in %0d datagrams sent, %0d results checked, %0d mismatches",
			items_sent, packets_sent, results_seen, errors);
		$display("short, bad id, bad magic, overrun and noise datagrams mixed in, "
			, "with a %0d-cycle output hold-off", HOLD_CYCLES);
		if (errors == 0 && expected_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ offline_pong_packet_parser.f @@
rtl/core/opp_pkg.sv
rtl/core/opp_parse.sv
rtl/core/opp_outq.sv
rtl/core/offline_pong_packet_parser.sv
dv/offline_pong_packet_parser_test.sv
